>>> design/dfs_pkg.sv
// Shared types and constants of the delimiter field splitter.
// Used by the register block, the split core, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    localparam int RESULT_W    = 16;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] REG_SPLIT_MODE  = 2'd0;
    localparam logic [1:0] REG_DELIM_BYTES = 2'd1;
    localparam logic [1:0] REG_DELIM_COUNT = 2'd2;

    localparam logic        SPLIT_MODE_SET = 1'b0;
    localparam logic        SPLIT_MODE_SEQ = 1'b1;

    localparam logic        RST_SPLIT_MODE  = SPLIT_MODE_SET;
    localparam logic [63:0] RST_DELIM_BYTES = 64'd44;
    localparam logic [3:0]  RST_DELIM_COUNT = 4'd1;

    typedef struct packed {
        logic        split_mode;
        logic [63:0] delimiter_bytes;
        logic [3:0]  delimiter_count;
    } t_cfg;

    typedef struct packed {
        logic [RESULT_W-1:0] field_offset;
        logic [RESULT_W-1:0] field_length;
        logic                closing_field;
        logic                overflow;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [7:0] delim_byte(input logic [63:0] bytes, input logic [2:0] j);
        return bytes[{j, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

>>> design/dfs_cfg_regs.sv
// Configuration registers behind the APB-style port.
// Depends on dfs_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module dfs_cfg_regs
    import dfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[4:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_mode      <= RST_SPLIT_MODE;
            r_cfg.delimiter_bytes <= RST_DELIM_BYTES;
            r_cfg.delimiter_count <= RST_DELIM_COUNT;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SPLIT_MODE:  r_cfg.split_mode      <= pwdata[0];
                REG_DELIM_BYTES: r_cfg.delimiter_bytes <= pwdata;
                REG_DELIM_COUNT: r_cfg.delimiter_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SPLIT_MODE:  prdata = APB_DATA_W'(r_cfg.split_mode);
            REG_DELIM_BYTES: prdata = r_cfg.delimiter_bytes;
            REG_DELIM_COUNT: prdata = APB_DATA_W'(r_cfg.delimiter_count);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/dfs_core.sv
// Input register, string state and single-pass delimiter match.
// Emits up to two field results per byte; depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfs_core
    import dfs_pkg::*;
#(
    parameter int MAX_DELIMITER = 8,
    parameter int OFFSET_BITS   = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_space,
    output t_push           o_push
);

    localparam int P    = OFFSET_BITS;
    localparam int HIST = (MAX_DELIMITER > 1) ? MAX_DELIMITER - 1 : 1;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic [P-1:0] r_pos;
    logic [P-1:0] r_cs;
    logic         r_sat;
    logic [7:0]   r_hist [HIST];

    logic         fire;
    logic [3:0]   cnt;
    logic [P:0]   idx1;
    logic [P:0]   cs_ext;
    logic [P:0]   cnt_ext;
    logic [P:0]   field_end;
    logic [P:0]   len_hit;
    logic [P:0]   len_fin;
    logic         set_hit;
    logic         seq_match;
    logic         win_ok;
    logic         hit;
    logic [3:0]   seq_idx;

    function automatic logic [P-1:0] clip(input logic [P:0] v);
        return v[P] ? {P{1'b1}} : v[P-1:0];
    endfunction

    function automatic t_result mk(input logic [P:0] off, input logic [P:0] len,
                                   input logic last, input logic sat);
        t_result r;
        r.field_offset  = RESULT_W'(clip(off));
        r.field_length  = RESULT_W'(clip(len));
        r.closing_field = last;
        r.overflow      = sat | off[P] | len[P];
        return r;
    endfunction

    assign fire    = r_in_valid & i_space;
    assign o_ready = ~r_in_valid | fire;

    always_comb begin
        cnt     = (i_cfg.delimiter_count > 4'(MAX_DELIMITER)) ? 4'(MAX_DELIMITER)
                                                               : i_cfg.delimiter_count;
        idx1    = {1'b0, r_pos} + (P+1)'(1);
        cs_ext  = {1'b0, r_cs};
        cnt_ext = (P+1)'(cnt);

        set_hit = 1'b0;
        for (int j = 0; j < MAX_DELIMITER; j++) begin
            if (4'(j) < cnt && delim_byte(i_cfg.delimiter_bytes, 3'(j)) == r_in_byte) begin
                set_hit = 1'b1;
            end
        end

        seq_idx   = cnt - 4'd1;
        seq_match = (delim_byte(i_cfg.delimiter_bytes, seq_idx[2:0]) == r_in_byte);
        for (int j = 1; j < MAX_DELIMITER; j++) begin
            seq_idx = cnt - 4'd1 - 4'(j);
            if (4'(j) < cnt &&
                r_hist[j-1] != delim_byte(i_cfg.delimiter_bytes, seq_idx[2:0])) begin
                seq_match = 1'b0;
            end
        end

        win_ok = (cnt != 4'd0) && (idx1 >= cnt_ext) && ((idx1 - cnt_ext) >= cs_ext);

        if (i_cfg.split_mode == SPLIT_MODE_SEQ) begin
            hit       = win_ok & seq_match;
            field_end = idx1 - cnt_ext;
        end else begin
            hit       = set_hit;
            field_end = {1'b0, r_pos};
        end

        len_hit = field_end - cs_ext;
        len_fin = idx1 - cs_ext;

        if (hit) begin
            o_push.r0 = mk(cs_ext, len_hit, 1'b0, r_sat);
            o_push.r1 = mk(idx1, '0, 1'b1, r_sat);
            o_push.n  = r_in_last ? 2'd2 : 2'd1;
        end else begin
            o_push.r0 = mk(cs_ext, len_fin, 1'b1, r_sat);
            o_push.r1 = o_push.r0;
            o_push.n  = r_in_last ? 2'd1 : 2'd0;
        end
        if (!fire) begin
            o_push.n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cs  <= '0;
            r_sat <= 1'b0;
            for (int k = 0; k < HIST; k++) begin
                r_hist[k] <= '0;
            end
        end else if (fire) begin
            if (r_in_last) begin
                r_pos <= '0;
                r_cs  <= '0;
                r_sat <= 1'b0;
            end else begin
                if (hit) begin
                    r_cs <= clip(idx1);
                end
                r_hist[0] <= r_in_byte;
                for (int k = 1; k < HIST; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
                if (r_pos != {P{1'b1}}) begin
                    r_pos <= r_pos + P'(1);
                end else begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/dfs_result_queue.sv
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on dfs_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module dfs_result_queue
    import dfs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid & i_ready;
    assign o_result = r_mem[r_rp];
    assign o_space  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wp + QPTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QPTR_W'(i_push.n);
            r_rp    <= r_rp + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.n) - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

>>> design/delimiter_field_splitter_top.sv
// Delimiter field splitter: string bytes in, field offset/length out.
// Each byte is held in the core's input register, then its results go into the result queue.
// Throughput: 1 byte per cycle while the queue has room; output drains one result per cycle
// from a 4-entry queue on m_axis_tready; a byte closing two fields gives two results.
// Reset (synchronous, active low) restores register defaults and clears string state.
// Depends on dfs_pkg, dfs_cfg_regs, dfs_core and dfs_result_queue.
`timescale 1ns / 1ps
`default_nettype none

module delimiter_field_splitter_top
    import dfs_pkg::*;
#(
    parameter int MAX_DELIMITER = 8,
    parameter int OFFSET_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [2*RESULT_W-1:0]      m_axis_tdata,  // [15:0] field_offset, [31:16] field_length
    output logic                       m_axis_tlast,
    output logic [0:0]                 m_axis_tuser   // [0] overflow
);

    t_cfg    cfg;
    t_push   push;
    logic    space;
    t_result res;

    dfs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dfs_core #(
        .MAX_DELIMITER (MAX_DELIMITER),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_space (space),
        .o_push  (push)
    );

    dfs_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tdata = {res.field_length, res.field_offset};
    assign m_axis_tlast = res.closing_field;
    assign m_axis_tuser = res.overflow;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench of the delimiter field splitter: a table of directed strings, then random strings
// under three idling profiles in set and sequence modes.
// Depends on dfs_pkg and delimiter_field_splitter_top; results are checked against a local model.
`timescale 1ns / 1ps

module tb;
    import dfs_pkg::*;

    localparam int unsigned OFF_MAX = (1 << RESULT_W) - 1;
    localparam int STALL_LIMIT = 1000;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [63:0] val;
        logic [7:0]  data;
        logic        fin;
        int          n_typed;
        t_result     r0;
        t_result     r1;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [2*RESULT_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    // register copies and per-string state of the splitter model
    logic        cfg_mode;
    logic [63:0] cfg_bytes;
    logic [3:0]  cfg_count;
    int unsigned str_pos;
    int unsigned fld_start;
    logic [7:0]  hist [7];
    logic        sat;

    t_result   fields_due [$];
    t_plan_row plan [$];
    int        mismatches;
    int        stall_cycles;
    int        send_idle;
    int        recv_idle;
    int        count_plan [12] = '{1, 8, 8, 2, 15, 0, 3, 1, 8, 4, 7, 2};

    delimiter_field_splitter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result fld(input int unsigned off, input int unsigned len,
                                    input logic cl, input logic ov);
        t_result r;
        r.field_offset  = off[RESULT_W-1:0];
        r.field_length  = len[RESULT_W-1:0];
        r.closing_field = cl;
        r.overflow      = ov;
        return r;
    endfunction

    function automatic t_result field_of(input int unsigned off, input int unsigned len,
                                         input logic cl);
        logic ovf;
        ovf = sat;
        if (off > OFF_MAX) begin
            off = OFF_MAX;
            ovf = 1'b1;
        end
        if (len > OFF_MAX) begin
            len = OFF_MAX;
            ovf = 1'b1;
        end
        return fld(off, len, cl, ovf);
    endfunction

    task automatic split_byte(input logic [7:0] b, input logic fin, input logic record);
        int unsigned idx;
        int unsigned fend;
        int          cnt;
        logic        hit;
        t_result     made [$];
        idx = str_pos;
        cnt = (cfg_count > 8) ? 8 : cfg_count;
        hit = 1'b0;
        fend = idx;
        if (cnt > 0) begin
            if (cfg_mode == SPLIT_MODE_SET) begin
                for (int j = 0; j < cnt; j++)
                    if (cfg_bytes[8*j +: 8] == b) hit = 1'b1;
            end else if (idx + 1 >= cnt && idx + 1 - cnt >= fld_start) begin
                hit = (cfg_bytes[8*(cnt-1) +: 8] == b);
                for (int j = 1; j < cnt; j++)
                    if (hist[j-1] != cfg_bytes[8*(cnt-1-j) +: 8]) hit = 1'b0;
                fend = idx + 1 - cnt;
            end
        end
        if (hit) begin
            made.push_back(field_of(fld_start, fend - fld_start, 1'b0));
            fld_start = idx + 1;
            if (fin) made.push_back(field_of(idx + 1, 0, 1'b1));
        end else if (fin) begin
            made.push_back(field_of(fld_start, idx + 1 - fld_start, 1'b1));
        end
        if (record) foreach (made[k]) fields_due.push_back(made[k]);
        if (fin) begin
            str_pos = 0;
            fld_start = 0;
            hist = '{default: 8'h00};
            sat = 1'b0;
        end else begin
            if (fld_start > OFF_MAX) fld_start = OFF_MAX;
            for (int k = 6; k > 0; k--) hist[k] = hist[k-1];
            hist[0] = b;
            if (str_pos < OFF_MAX) str_pos++;
            else sat = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic record);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        split_byte(b, fin, record);
    endtask

    // hold the input, wait for every expected field, then let the pipeline settle
    task automatic drain(input int settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (fields_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        drain(8);
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SPLIT_MODE:  cfg_mode  = val[0];
            REG_DELIM_BYTES: cfg_bytes = val;
            REG_DELIM_COUNT: cfg_count = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_reg(input logic [1:0] idx, input logic [63:0] val);
        t_plan_row r;
        r = '{kind: ROW_REG, idx: idx, val: val, data: 8'h00, fin: 1'b0, n_typed: 0,
              r0: '0, r1: '0};
        plan.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] data, input logic fin, input int n,
                            input t_result r0, input t_result r1);
        t_plan_row r;
        r = '{kind: ROW_BYTE, idx: REG_SPLIT_MODE, val: '0, data: data, fin: fin, n_typed: n,
              r0: r0, r1: r1};
        plan.push_back(r);
    endtask

    // mostly well-formed fields: whole delimiters, broken ones, set bytes and noise
    task automatic send_random_string(output int sent);
        int         len;
        int         cnt;
        int         pick;
        int         m;
        logic [7:0] chars [$];
        cnt = (cfg_count > 8) ? 8 : cfg_count;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        while (chars.size() < len) begin
            pick = $urandom_range(99);
            if (pick < 25 && cnt > 0) begin
                if (cfg_mode == SPLIT_MODE_SEQ) begin
                    for (int j = 0; j < cnt; j++) chars.push_back(cfg_bytes[8*j +: 8]);
                end else begin
                    m = $urandom_range(cnt - 1);
                    chars.push_back(cfg_bytes[8*m +: 8]);
                end
            end else if (pick < 35 && cnt > 1 && cfg_mode == SPLIT_MODE_SEQ) begin
                m = $urandom_range(1, cnt - 1);
                for (int j = 0; j < m; j++) chars.push_back(cfg_bytes[8*j +: 8]);
            end else if (pick < 65) begin
                m = $urandom_range(7);
                chars.push_back(cfg_bytes[8*m +: 8]);
            end else begin
                chars.push_back(8'($urandom_range(255)));
            end
        end
        foreach (chars[i]) send_byte(chars[i], i == chars.size() - 1, 1'b1);
        sent = chars.size();
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.field_offset  = m_axis_tdata[RESULT_W-1:0];
            got.field_length  = m_axis_tdata[2*RESULT_W-1:RESULT_W];
            got.closing_field = m_axis_tlast;
            got.overflow      = m_axis_tuser[0];
            if (fields_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected field: offset %0d length %0d closing %0b overflow %0b",
                         $time, got.field_offset, got.field_length, got.closing_field,
                         got.overflow);
            end else begin
                want = fields_due.pop_front();
                if (got.field_offset !== want.field_offset
                        || got.field_length !== want.field_length
                        || got.closing_field !== want.closing_field
                        || got.overflow !== want.overflow) begin
                    mismatches++;
                    $display("%0t: field mismatch: expected offset %0d length %0d closing %0b %s",
                             $time, want.field_offset, want.field_length, want.closing_field,
                             $sformatf("overflow %0b, got offset %0d length %0d closing %0b %s",
                                       want.overflow, got.field_offset, got.field_length,
                                       got.closing_field,
                                       $sformatf("overflow %0b", got.overflow)));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          s;
        int          sent;
        int          n;
        logic [63:0] pattern;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        stall_cycles  = 0;
        send_idle     = 38;
        recv_idle     = 65;
        cfg_mode      = RST_SPLIT_MODE;
        cfg_bytes     = RST_DELIM_BYTES;
        cfg_count     = RST_DELIM_COUNT;
        str_pos       = 0;
        fld_start     = 0;
        hist          = '{default: 8'h00};
        sat           = 1'b0;

        // reset settings: comma is the only delimiter
        add_byte(8'h61, 1'b0, 0, '0, '0);
        add_byte(8'h2C, 1'b0, 1, fld(0, 1, 1'b0, 1'b0), '0);
        add_byte(8'hFF, 1'b1, 1, fld(2, 1, 1'b1, 1'b0), '0);
        add_byte(8'h2C, 1'b1, 2, fld(0, 0, 1'b0, 1'b0), fld(1, 0, 1'b1, 1'b0));
        add_byte(8'h00, 1'b1, 1, fld(0, 1, 1'b1, 1'b0), '0);
        add_reg(REG_DELIM_BYTES, 64'h0000_0000_00FF_3B2C);
        add_reg(REG_DELIM_COUNT, 64'd4);
        add_byte(8'h3B, 1'b0, -1, '0, '0);
        add_byte(8'h80, 1'b0, -1, '0, '0);
        add_byte(8'h00, 1'b1, -1, '0, '0);
        // empty set: the whole string is one field
        add_reg(REG_DELIM_COUNT, 64'd0);
        add_byte(8'h2C, 1'b0, 0, '0, '0);
        add_byte(8'h2C, 1'b1, 1, fld(0, 2, 1'b1, 1'b0), '0);
        add_reg(REG_DELIM_COUNT, 64'd15);
        add_byte(8'h7F, 1'b1, -1, '0, '0);
        // two-byte sequence, overlapping starts and a broken sequence at the end
        add_reg(REG_SPLIT_MODE, 64'(SPLIT_MODE_SEQ));
        add_reg(REG_DELIM_BYTES, 64'h7978);
        add_reg(REG_DELIM_COUNT, 64'd2);
        add_byte(8'h78, 1'b0, -1, '0, '0);
        add_byte(8'h79, 1'b0, -1, '0, '0);
        add_byte(8'h78, 1'b0, -1, '0, '0);
        add_byte(8'h78, 1'b0, -1, '0, '0);
        add_byte(8'h79, 1'b0, -1, '0, '0);
        add_byte(8'h78, 1'b1, -1, '0, '0);
        add_byte(8'h79, 1'b1, -1, '0, '0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_byte(plan[i].data, plan[i].fin, plan[i].n_typed < 0);
                if (plan[i].n_typed > 0) fields_due.push_back(plan[i].r0);
                if (plan[i].n_typed > 1) fields_due.push_back(plan[i].r1);
            end
        end

        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 38 : (p == 1) ? 65 : 0;
            recv_idle = (p == 0) ? 65 : (p == 1) ? 38 : 0;
            for (int k = 0; k < 4; k++) begin
                s = 4 * p + k;
                pattern = {$urandom, $urandom};
                if (s % 3 == 1)
                    for (int j = 0; j < 8; j++)
                        pattern[8*j +: 8] = ($urandom_range(1) == 0) ? 8'h2C : 8'h2D;
                if (s == 2) pattern = '1;
                if (s == 5) pattern = '0;
                write_reg(REG_SPLIT_MODE,
                          64'((s % 2 == 1) ? SPLIT_MODE_SEQ : SPLIT_MODE_SET));
                write_reg(REG_DELIM_BYTES, pattern);
                write_reg(REG_DELIM_COUNT, 64'(count_plan[s]));
                sent = 0;
                while (sent < 112) begin
                    send_random_string(n);
                    sent += n;
                end
            end
        end

        drain(20);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
